// ===== rtl/button_hold_double_press_detector_assert.svh =====
`ifndef BUTTON_HOLD_DOUBLE_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_HOLD_DOUBLE_PRESS_DETECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BHDP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define BHDP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/bhdp_pkg.sv =====
`timescale 1ns / 1ps

package bhdp_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0]   count_t;
    typedef logic [CFG_WIDTH-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
    typedef logic [CMP_WIDTH-1:0]     cmp_t;

    localparam cfg_idx_t CFG_HOLD_TICKS = 2'd0;
    localparam cfg_idx_t CFG_DOUBLE_GAP = 2'd1;

    localparam cfg_data_t HOLD_TICKS_RST = 16'd5000;
    localparam cfg_data_t DOUBLE_GAP_RST = 16'd700;

    localparam count_t CNT_MAX = '1;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_PRESS_BEGIN  = 3'd1,
        EV_LONG_HOLD    = 3'd2,
        EV_UPLOAD_EXIT  = 3'd3,
        EV_DOUBLE_PRESS = 3'd4
    } event_code_t;

    typedef struct packed {
        logic button_down;
        logic upload_active;
    } tick_word_t;

    function automatic count_t sat_inc(count_t v);
        count_t r;
        r = (v == CNT_MAX) ? CNT_MAX : v + count_t'(1);
        return r;
    endfunction

endpackage

// ===== rtl/bhdp_in_reg.sv =====
`timescale 1ns / 1ps

module bhdp_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhdp_pkg::tick_word_t s_word,
    input  logic                take,
    output logic                word_vld,
    output bhdp_pkg::tick_word_t word
);

    logic                 vld_reg;
    logic                 vld_next;
    bhdp_pkg::tick_word_t word_reg;

    assign s_ready  = !vld_reg || take;
    assign word_vld = vld_reg;
    assign word     = word_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

// ===== rtl/bhdp_core.sv =====
`timescale 1ns / 1ps
`include "button_hold_double_press_detector_assert.svh"

module bhdp_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  bhdp_pkg::cfg_idx_t     cfg_index,
    input  bhdp_pkg::cfg_data_t    cfg_wdata,
    input  logic                   adv,
    input  bhdp_pkg::tick_word_t   word,
    output bhdp_pkg::event_code_t  ev
);

    bhdp_pkg::cfg_data_t hold_ticks_reg;
    bhdp_pkg::cfg_data_t double_gap_reg;

    logic            was_reg,   was_next;
    logic            hand_reg,  hand_next;
    logic            rel_reg,   rel_next;
    bhdp_pkg::count_t hold_reg,  hold_next;
    bhdp_pkg::count_t since_reg, since_next;

    bhdp_pkg::count_t hold_inc;
    bhdp_pkg::count_t since_inc;
    bhdp_pkg::cmp_t   hold_cmp;
    bhdp_pkg::cmp_t   since_cmp;
    bhdp_pkg::cmp_t   ticks_cmp;
    bhdp_pkg::cmp_t   gap_cmp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= bhdp_pkg::HOLD_TICKS_RST;
            double_gap_reg <= bhdp_pkg::DOUBLE_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bhdp_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg_wdata;
                bhdp_pkg::CFG_DOUBLE_GAP: double_gap_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // counters advance first, decision uses advanced values
    assign hold_inc  = was_reg ? bhdp_pkg::sat_inc(hold_reg) : hold_reg;
    assign since_inc = rel_reg ? bhdp_pkg::sat_inc(since_reg) : since_reg;
    assign hold_cmp  = bhdp_pkg::CMP_WIDTH'(hold_inc);
    assign since_cmp = bhdp_pkg::CMP_WIDTH'(since_inc);
    assign ticks_cmp = bhdp_pkg::CMP_WIDTH'(hold_ticks_reg);
    assign gap_cmp   = bhdp_pkg::CMP_WIDTH'(double_gap_reg);

    always_comb begin
        ev         = bhdp_pkg::EV_NONE;
        was_next   = was_reg;
        hand_next  = hand_reg;
        rel_next   = rel_reg;
        hold_next  = hold_inc;
        since_next = since_inc;
        if (word.upload_active) begin
            if (word.button_down) begin
                if (!was_reg) begin
                    was_next  = 1'b1;
                    hand_next = 1'b1;
                    ev        = bhdp_pkg::EV_UPLOAD_EXIT;
                end
            end else begin
                was_next  = 1'b0;
                hand_next = 1'b0;
                hold_next = '0;
            end
        end else if (word.button_down) begin
            if (!was_reg) begin
                was_next  = 1'b1;
                hand_next = 1'b0;
                hold_next = '0;
                ev        = bhdp_pkg::EV_PRESS_BEGIN;
            end else if (!hand_reg && (hold_cmp >= ticks_cmp)) begin
                hand_next = 1'b1;
                ev        = bhdp_pkg::EV_LONG_HOLD;
            end
        end else begin
            // release: only a short press (not handled as a long hold) counts toward a double press
            if (was_reg && !hand_reg) begin
                if (rel_reg && (since_cmp <= gap_cmp)) begin
                    ev         = bhdp_pkg::EV_DOUBLE_PRESS;
                    rel_next   = 1'b0;
                    since_next = '0;
                end else begin
                    rel_next   = 1'b1;
                    since_next = '0;
                end
            end
            was_next  = 1'b0;
            hand_next = 1'b0;
            hold_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_reg   <= 1'b0;
            hand_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            hold_reg  <= '0;
            since_reg <= '0;
        end else if (adv) begin
            was_reg   <= was_next;
            hand_reg  <= hand_next;
            rel_reg   <= rel_next;
            hold_reg  <= hold_next;
            since_reg <= since_next;
        end
    end

    `BHDP_ASSERT_NOW(a_hold_idle, aclk, aresetn, !was_reg, hold_reg == '0)
    `BHDP_ASSERT_NOW(a_handled_pressed, aclk, aresetn, hand_reg, was_reg)
    `BHDP_ASSERT_NEXT(a_double_clears, aclk, aresetn,
        adv && (ev == bhdp_pkg::EV_DOUBLE_PRESS), !rel_reg && (since_reg == '0))

endmodule

// ===== rtl/bhdp_out_reg.sv =====
`timescale 1ns / 1ps

module bhdp_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  bhdp_pkg::event_code_t ev,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_event_code
);

    logic                  vld_reg;
    logic                  vld_next;
    bhdp_pkg::event_code_t ev_reg;

    assign room         = !vld_reg || m_ready;
    assign m_valid      = vld_reg;
    assign m_event_code = ev_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_reg <= ev;
        end
    end

endmodule

// ===== rtl/button_hold_double_press_detector.sv =====
// A word waits in the input register, then its event code loads into the result register.
// Throughput: one word per cycle unless m_ready low stalls the result register.
// The input register takes a new word while the result register still holds one.
// Reset (aresetn low, synchronous): channels empty, detector state cleared,
// hold_ticks back to 5000 and double_gap_ticks to 700.
`timescale 1ns / 1ps

module button_hold_double_press_detector (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_button_down,
    input  logic                      s_upload_active,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_event_code,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_wdata
);

    bhdp_pkg::tick_word_t  s_word;
    bhdp_pkg::tick_word_t  word;
    bhdp_pkg::event_code_t ev;
    logic                  word_vld;
    logic                  room;
    logic                  adv;

    assign s_word.button_down   = s_button_down;
    assign s_word.upload_active = s_upload_active;
    assign adv = word_vld && room;

    bhdp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .take     (adv),
        .word_vld (word_vld),
        .word     (word)
    );

    bhdp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .adv       (adv),
        .word      (word),
        .ev        (ev)
    );

    bhdp_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (adv),
        .ev           (ev),
        .room         (room),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code)
    );

endmodule
